/* rtl/cdc_pkg.sv */
`default_nettype none

package cdc_pkg;

    localparam int COUNT_BITS = 16;
    localparam int YEAR_BITS  = 12;
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX   = {YEAR_BITS{1'b1}};
    localparam logic [YEAR_BITS-1:0] YEAR_FIRST = YEAR_BITS'(1900);
    localparam logic [YEAR_BITS-1:0] YEAR_LAST  = YEAR_BITS'(2100);

    localparam logic [MONTH_BITS-1:0] MONTH_FIRST = MONTH_BITS'(1);
    localparam logic [MONTH_BITS-1:0] MONTH_FEB   = MONTH_BITS'(2);
    localparam logic [MONTH_BITS-1:0] MONTH_LAST  = MONTH_BITS'(12);
    localparam logic [DAY_BITS-1:0]   DAY_FIRST   = DAY_BITS'(1);
    localparam logic [DAY_BITS-1:0]   LEAP_FEB_DAYS = DAY_BITS'(29);

    // Residues of the year kept alongside it for the leap rule.
    localparam int MOD100_BITS = 7;
    localparam int MOD400_BITS = 9;
    localparam logic [MOD100_BITS-1:0] MOD100_LAST  = MOD100_BITS'(99);
    localparam logic [MOD400_BITS-1:0] MOD400_LAST  = MOD400_BITS'(399);
    localparam logic [MOD400_BITS-1:0] MOD400_FIRST = MOD400_BITS'(300); // 1900 mod 400
    localparam int YEAR_SPAN_BITS = 8;  // offset from 1900 stays below 201

    typedef logic [DAY_BITS-1:0] t_month_len [16];
    localparam t_month_len MONTH_LEN = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef enum logic [1:0] {
        KIND_SET  = 2'd0,
        KIND_PRE  = 2'd1,
        KIND_POST = 2'd2,
        KIND_ADD  = 2'd3
    } t_kind;

    function automatic logic [DAY_BITS-1:0] f_days_in(
        input logic [MONTH_BITS-1:0] month,
        input logic                  leap
    );
        logic [DAY_BITS-1:0] len;
        len = MONTH_LEN[month];
        if (month == MONTH_FEB && leap) begin
            len = LEAP_FEB_DAYS;
        end
        return len;
    endfunction

    function automatic logic f_leap(
        input logic [1:0]             year_lsbs,
        input logic [MOD100_BITS-1:0] mod100,
        input logic [MOD400_BITS-1:0] mod400
    );
        return (mod400 == '0) || ((mod100 != '0) && (year_lsbs == 2'b00));
    endfunction

endpackage

`default_nettype wire

/* rtl/calendar_date_counter.sv */
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+------------------------------------------
// command   | in        | i_in_valid / o_in_ready  | i_kind, i_new_month, i_new_day,
//           |           |                          | i_new_year, i_day_count
// result    | out       | o_out_valid / i_out_ready| o_out_month, o_out_day, o_out_year,
//           |           |                          | o_year_overflow
//
// Steps: set goes from accept to the result load; pre/post increment steps one day and add steps
//   day_count days, one day per cycle through the single day-advance unit, then both check for
//   an empty count and load the result; the stepping stops early when the last year blocks.
// One transaction is in flight at a time; o_in_ready is high only while idle.
// The result register lets a finished result wait while the next command is taken;
// a new result holds in the sequencer until the result register is free.
// Reset (synchronous, active low) loads Jan 1 1900 and empties the result register.
`default_nettype none

module calendar_date_counter
    import cdc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire logic [1:0]            i_kind,
    input  wire logic [MONTH_BITS-1:0] i_new_month,
    input  wire logic [DAY_BITS-1:0]   i_new_day,
    input  wire logic [YEAR_BITS-1:0]  i_new_year,
    input  wire logic [COUNT_BITS-1:0] i_day_count,

    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      logic [MONTH_BITS-1:0] o_out_month,
    output      logic [DAY_BITS-1:0]   o_out_day,
    output      logic [YEAR_BITS-1:0]  o_out_year,
    output      logic                  o_year_overflow
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_STEP = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Current date and the year residues that drive the leap rule.
    logic [MONTH_BITS-1:0]  r_month, n_month;
    logic [DAY_BITS-1:0]    r_day, n_day;
    logic [YEAR_BITS-1:0]   r_year, n_year;
    logic [MOD100_BITS-1:0] r_mod100, n_mod100;
    logic [MOD400_BITS-1:0] r_mod400, n_mod400;

    // Per-transaction bookkeeping.
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic                   r_post, n_post;
    logic                   r_ovf, n_ovf;
    logic [MONTH_BITS-1:0]  r_snap_month, n_snap_month;
    logic [DAY_BITS-1:0]    r_snap_day, n_snap_day;
    logic [YEAR_BITS-1:0]   r_snap_year, n_snap_year;

    // Result register.
    logic                   r_out_valid, n_out_valid;
    logic [MONTH_BITS-1:0]  r_out_month, n_out_month;
    logic [DAY_BITS-1:0]    r_out_day, n_out_day;
    logic [YEAR_BITS-1:0]   r_out_year, n_out_year;
    logic                   r_out_ovf, n_out_ovf;

    logic                   in_fire;
    logic                   out_free;

    // Set path: validate the loaded date.
    logic                   set_m_ok;
    logic                   set_y_ok;
    logic [MONTH_BITS-1:0]  set_month;
    logic [YEAR_BITS-1:0]   set_year;
    logic [YEAR_BITS-1:0]   set_span_full;
    logic [YEAR_SPAN_BITS-1:0] set_span;
    logic [MOD100_BITS-1:0] set_mod100;
    logic [MOD400_BITS-1:0] set_mod400_sum;
    logic [MOD400_BITS-1:0] set_mod400;
    logic                   set_leap;
    logic                   set_d_ok;
    logic [DAY_BITS-1:0]    set_day;

    // Day-advance unit.
    logic                   cur_leap;
    logic                   last_day;
    logic                   year_end;
    logic                   blocked;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        set_m_ok      = (i_new_month >= MONTH_FIRST) && (i_new_month <= MONTH_LAST);
        set_month     = set_m_ok ? i_new_month : MONTH_FIRST;
        set_y_ok      = (i_new_year >= YEAR_FIRST) && (i_new_year <= YEAR_LAST);
        set_year      = set_y_ok ? i_new_year : YEAR_FIRST;
        set_span_full = set_year - YEAR_FIRST;
        set_span      = set_span_full[YEAR_SPAN_BITS-1:0];
        // 1900 is a multiple of 100, so the offset reduces to the residue.
        if (set_span >= YEAR_SPAN_BITS'(200)) begin
            set_mod100 = MOD100_BITS'(set_span - YEAR_SPAN_BITS'(200));
        end else if (set_span >= YEAR_SPAN_BITS'(100)) begin
            set_mod100 = MOD100_BITS'(set_span - YEAR_SPAN_BITS'(100));
        end else begin
            set_mod100 = MOD100_BITS'(set_span);
        end
        set_mod400_sum = MOD400_BITS'(set_span) + MOD400_FIRST;
        if (set_mod400_sum > MOD400_LAST) begin
            set_mod400 = set_mod400_sum - MOD400_BITS'(400);
        end else begin
            set_mod400 = set_mod400_sum;
        end
        set_leap = f_leap(set_year[1:0], set_mod100, set_mod400);
        set_d_ok = (i_new_day >= DAY_FIRST) && (i_new_day <= f_days_in(set_month, set_leap));
        set_day  = set_d_ok ? i_new_day : DAY_FIRST;
    end

    always_comb begin
        cur_leap = f_leap(r_year[1:0], r_mod100, r_mod400);
        last_day = r_day >= f_days_in(r_month, cur_leap);
        year_end = last_day && (r_month >= MONTH_LAST);
        blocked  = year_end && (r_year >= YEAR_MAX);
    end

    always_comb begin
        n_state      = r_state;
        n_month      = r_month;
        n_day        = r_day;
        n_year       = r_year;
        n_mod100     = r_mod100;
        n_mod400     = r_mod400;
        n_count      = r_count;
        n_post       = r_post;
        n_ovf        = r_ovf;
        n_snap_month = r_snap_month;
        n_snap_day   = r_snap_day;
        n_snap_year  = r_snap_year;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_month  = r_out_month;
        n_out_day    = r_out_day;
        n_out_year   = r_out_year;
        n_out_ovf    = r_out_ovf;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_ovf        = 1'b0;
                    n_post       = (i_kind == KIND_POST);
                    // Keep the old date for a post-increment report.
                    n_snap_month = r_month;
                    n_snap_day   = r_day;
                    n_snap_year  = r_year;
                    unique case (t_kind'(i_kind))
                        KIND_SET: begin
                            n_month  = set_month;
                            n_day    = set_day;
                            n_year   = set_year;
                            n_mod100 = set_mod100;
                            n_mod400 = set_mod400;
                            n_state  = S_DONE;
                        end
                        KIND_ADD: begin
                            n_count = i_day_count;
                            n_state = S_STEP;
                        end
                        default: begin
                            n_count = COUNT_BITS'(1);
                            n_state = S_STEP;
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (r_count == '0) begin
                    n_state = S_DONE;
                end else if (blocked) begin
                    // Hold at Dec 31 of the last year and drop the rest of the count.
                    n_ovf   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_count = r_count - COUNT_BITS'(1);
                    if (year_end) begin
                        n_day    = DAY_FIRST;
                        n_month  = MONTH_FIRST;
                        n_year   = r_year + YEAR_BITS'(1);
                        n_mod100 = (r_mod100 == MOD100_LAST) ? '0 : r_mod100 + MOD100_BITS'(1);
                        n_mod400 = (r_mod400 == MOD400_LAST) ? '0 : r_mod400 + MOD400_BITS'(1);
                    end else if (last_day) begin
                        n_day   = DAY_FIRST;
                        n_month = r_month + MONTH_BITS'(1);
                    end else begin
                        n_day = r_day + DAY_BITS'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_month = r_post ? r_snap_month : r_month;
                    n_out_day   = r_post ? r_snap_day   : r_day;
                    n_out_year  = r_post ? r_snap_year  : r_year;
                    n_out_ovf   = r_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_month     <= MONTH_FIRST;
            r_day       <= DAY_FIRST;
            r_year      <= YEAR_FIRST;
            r_mod100    <= '0;
            r_mod400    <= MOD400_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_month     <= n_month;
            r_day       <= n_day;
            r_year      <= n_year;
            r_mod100    <= n_mod100;
            r_mod400    <= n_mod400;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count      <= n_count;
        r_post       <= n_post;
        r_ovf        <= n_ovf;
        r_snap_month <= n_snap_month;
        r_snap_day   <= n_snap_day;
        r_snap_year  <= n_snap_year;
        r_out_month  <= n_out_month;
        r_out_day    <= n_out_day;
        r_out_year   <= n_out_year;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_out_month     = r_out_month;
    assign o_out_day       = r_out_day;
    assign o_out_year      = r_out_year;
    assign o_year_overflow = r_out_ovf;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("command taken while a transaction is in flight");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month >= MONTH_FIRST) && (r_month <= MONTH_LAST))
        else $error("current month out of range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_day >= DAY_FIRST) && (r_day <= f_days_in(r_month, cur_leap)))
        else $error("current day beyond month length");

    a_residues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mod100 <= MOD100_LAST) && (r_mod400 <= MOD400_LAST)
        && (r_mod100[1:0] == r_year[1:0]) && (r_mod400[1:0] == r_year[1:0]))
        else $error("year residues out of step with the year");

    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) && (r_count == '0) |=> (r_state == S_DONE))
        else $error("sequencer did not finish on an exhausted count");

endmodule

`default_nettype wire
